@@ rtl/lfu_victim_selector_core_defines.svh @@
// Assertion macros used by the LFU victim selector core
`ifndef LFU_VICTIM_SELECTOR_CORE_DEFINES_SVH
`define LFU_VICTIM_SELECTOR_CORE_DEFINES_SVH

// implication in the same cycle
`define LVS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle
`define LVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lvs_pkg.sv @@
// Package: sizes, request codes and shared types of the LFU victim selector
`default_nettype none
package lvs_pkg;

  localparam int NUM_SETS   = 1024;
  localparam int NUM_WAYS   = 8;
  localparam int COUNT_BITS = 8;

  localparam int REQ_W   = 2;
  localparam int SET_W   = 10;
  localparam int WAY_W   = 3;
  localparam int UPPER_W = 8;

  localparam int ADDR_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_IW  = $clog2(NUM_WAYS);
  localparam int ROW_W   = NUM_WAYS * COUNT_BITS;
  localparam int UMASK_W = (NUM_WAYS > UPPER_W) ? NUM_WAYS : UPPER_W;

  localparam logic [REQ_W-1:0] REQ_INVAL = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FILL  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_HIT   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

  typedef struct packed {
    logic [WAY_W-1:0] way;
    logic             invalid;
  } pick_t;

endpackage
`default_nettype wire

@@ rtl/lfu_victim_selector_core.sv @@
// Top level: LFU replacement state, request sequencer and result register
// A query's result word passes the registered count RAM read, then the result register.
// One request at a time: a new one is accepted only once the last leaves lookup;
// a query holds in lookup while the previous result word waits for out_ready.
// Reset: synchronous, active low; second_level_mode returns to 0 and a clearing
// pass over all 1024 sets zeroes the count RAM, one set a cycle, with in_ready low.
`default_nettype none
`include "lfu_victim_selector_core_defines.svh"
module lfu_victim_selector_core
  import lvs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_second_level_mode,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [REQ_W-1:0]   in_req_type,
  input  wire logic [SET_W-1:0]   in_set_index,
  input  wire logic [WAY_W-1:0]   in_way_index,
  input  wire logic [UPPER_W-1:0] in_in_upper_mask,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [WAY_W-1:0]        out_victim_way,
  output logic                    out_victim_invalid
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic                  mode_r;
  logic [REQ_W-1:0]      req_r;
  logic [ADDR_W-1:0]     addr_r;
  logic [WAY_W-1:0]      way_r;
  logic [UPPER_W-1:0]    upper_r;
  logic                  set_ok_r;
  logic                  way_ok_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [WAY_W-1:0]      out_way_r;
  logic                  out_inv_r;

  logic                  in_fire;
  logic                  is_query;
  logic                  load_out;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [ROW_W-1:0]      rd_row;
  logic [ROW_W-1:0]      new_row;
  logic [WAY_IW-1:0]     way_sel;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  pick_t                 pick;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_query  = (req_r == REQ_QUERY);
  assign load_out  = (state_r == ST_LOOK) && is_query && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_second_level_mode;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(NUM_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!is_query || load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // hold the accepted word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r    <= in_req_type;
      addr_r   <= ADDR_W'(in_set_index);
      way_r    <= in_way_index;
      upper_r  <= in_in_upper_mask;
      set_ok_r <= (32'(in_set_index) < NUM_SETS);
      way_ok_r <= (32'(in_way_index) < NUM_WAYS);
    end
  end

  lvs_ram #(
    .DEPTH (NUM_SETS),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (ADDR_W'(in_set_index)),
    .rdata (rd_row)
  );

  assign way_sel = WAY_IW'(way_r);
  assign cur_cnt = rd_row[way_sel*COUNT_BITS +: COUNT_BITS];

  always_comb begin
    case (req_r)
      REQ_INVAL: new_cnt = '0;
      REQ_FILL:  new_cnt = COUNT_BITS'(1);
      REQ_HIT:   new_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
      default:   new_cnt = cur_cnt;
    endcase
  end

  always_comb begin
    new_row = rd_row;
    new_row[way_sel*COUNT_BITS +: COUNT_BITS] = new_cnt;
  end

  assign ram_we    = (state_r == ST_CLEAR) ||
                     ((state_r == ST_LOOK) && !is_query && set_ok_r && way_ok_r);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : addr_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : new_row;

  lvs_pick u_pick (
    .row          (rd_row),
    .upper_mask   (upper_r),
    .second_level (mode_r),
    .pick         (pick)
  );

  assign out_valid_nxt = load_out || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_way_r <= set_ok_r ? pick.way : '0;
      out_inv_r <= set_ok_r ? pick.invalid : 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_victim_way     = out_way_r;
  assign out_victim_invalid = out_inv_r;

  `LVS_ASSERT_NEXT(a_fire_to_look, in_fire, state_r == ST_LOOK,
                   "accepted word did not reach lookup")
  `LVS_ASSERT_SAME(a_we_not_idle, ram_we, state_r != ST_IDLE,
                   "count RAM written while idle")
  `LVS_ASSERT_SAME(a_rise_after_look, $rose(out_valid_r), $past(state_r) == ST_LOOK,
                   "result word without lookup")
  `LVS_ASSERT_NEXT(a_update_done, (state_r == ST_LOOK) && !is_query, state_r == ST_IDLE,
                   "update held in lookup")

endmodule
`default_nettype wire

@@ rtl/lvs_ram.sv @@
// Simple dual-port RAM with registered read data
`default_nettype none
module lvs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/lvs_pick.sv @@
// Victim choice over one row of use counters
`default_nettype none
module lvs_pick
  import lvs_pkg::*;
(
  input  wire logic [ROW_W-1:0]   row,
  input  wire logic [UPPER_W-1:0] upper_mask,
  input  wire logic               second_level,
  output pick_t                   pick
);

  logic [UMASK_W-1:0]    upper_x;
  logic [NUM_WAYS-1:0]   inv;
  logic [NUM_WAYS-1:0]   pres;
  logic [NUM_WAYS-1:0]   absent;
  logic [NUM_WAYS-1:0]   sel;
  logic                  found;
  logic [WAY_IW-1:0]     best_idx;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [COUNT_BITS-1:0] cnt;

  assign upper_x = UMASK_W'(upper_mask);

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      inv[w]    = (row[w*COUNT_BITS +: COUNT_BITS] == '0);
      pres[w]   = !inv[w] && upper_x[w];
      absent[w] = !inv[w] && !upper_x[w];
    end
  end

  always_comb begin
    if (|inv) begin
      sel = inv;
    end else if (!second_level) begin
      sel = '1;
    end else if (|absent) begin
      sel = absent;
    end else begin
      sel = pres;
    end
  end

  always_comb begin
    found    = 1'b0;
    best_idx = '0;
    best_cnt = '0;
    cnt      = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      cnt = row[w*COUNT_BITS +: COUNT_BITS];
      if (sel[w] && (!found || (cnt < best_cnt))) begin
        found    = 1'b1;
        best_idx = WAY_IW'(w);
        best_cnt = cnt;
      end
    end
  end

  assign pick.way     = WAY_W'(best_idx);
  assign pick.invalid = (best_cnt == '0);

endmodule
`default_nettype wire
